// File: src/qsd_pkg.sv
// Shared types, widths and codes for the q-ary syndrome table decoder.
// No dependencies; every other file imports this package.
package qsd_pkg;

   localparam int TableDepthDefault = 65536;
   localparam int SymbolBitsDefault = 15;

   localparam int SymW       = 15;           // symbol, modulus and generator width
   localparam int RemW       = SymW + 1;     // residue below twice the modulus
   localparam int IdxW       = 16;
   localparam int KeyW       = 3 * SymW;     // packed syndrome before range check
   localparam int ProdW      = 2 * SymW;
   localparam int RecipShift = 2 * SymW;
   localparam int RecipW     = 2 * SymW;
   localparam int ReqDataW   = 136;
   localparam int RspDataW   = 128;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic [1:0] ST_DECODED = 2'd0;
   localparam logic [1:0] ST_WRITTEN = 2'd1;
   localparam logic [1:0] ST_RANGE   = 2'd2;
   localparam logic [1:0] ST_SYMBOL  = 2'd3;

   localparam logic [2:0] REG_LENGTH     = 3'd0;
   localparam logic [2:0] REG_MODULUS    = 3'd1;
   localparam logic [2:0] REG_GEN_SECOND = 3'd2;
   localparam logic [2:0] REG_GEN_THIRD  = 3'd3;
   localparam logic [2:0] REG_GEN_FOURTH = 3'd4;

   localparam logic [2:0]      LEN_RESET  = 3'd2;
   localparam logic [2:0]      LEN_MIN    = 3'd2;
   localparam logic [2:0]      LEN_MAX    = 3'd4;
   localparam logic [SymW-1:0] MOD_RESET  = 15'd631;
   localparam logic [SymW-1:0] MOD_MIN    = 15'd2;
   localparam logic [SymW-1:0] GEN2_RESET = 15'd73;
   localparam logic [SymW-1:0] GEN3_RESET = 15'd0;
   localparam logic [SymW-1:0] GEN4_RESET = 15'd0;
   localparam logic [IdxW-1:0] IDX_SAT    = 16'hFFFF;

   typedef logic [SymW-1:0] sym_type;

   // clamped configuration plus the reciprocal of the modulus
   typedef struct packed {
      logic [2:0]        len;
      sym_type           q;
      sym_type [2:0]     gen;
      logic [RecipW-1:0] recip;
   } cfg_type;

   typedef struct packed {
      logic            op;
      logic            bad;
      logic            hit;
      logic [IdxW-1:0] entry;
      sym_type [3:0]   err;
      sym_type [3:0]   sym;
      sym_type [2:0]   syn;
      logic [KeyW-1:0] key;
   } item_type;

   typedef struct packed {
      logic [1:0]      status;
      sym_type [3:0]   word;
      sym_type [2:0]   syn;
      logic [IdxW-1:0] index;
      logic            codeword;
   } result_type;

endpackage

// File: src/qsd_recip.sv
// Bit-serial divider: floor(2^RecipShift / q), one quotient bit per cycle.
// Uses qsd_pkg.
module qsd_recip
   import qsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  sym_type           divisor,
   output logic              busy,
   output logic [RecipW-1:0] recip
);

   localparam int StepW = $clog2(RecipShift + 1);
   localparam logic [StepW-1:0] LAST_STEP = StepW'(RecipShift);

   logic              busy_ff, busy_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic [SymW-1:0]   rem_ff, rem_in;
   logic [RecipW-1:0] quo_ff, quo_in;
   logic [SymW:0]     shifted;
   logic              fits;

   always_comb begin
      // dividend is a single one at the top bit
      shifted = {rem_ff, (step_ff == LAST_STEP)};
      fits    = shifted >= {1'b0, divisor};
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = LAST_STEP;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? SymW'(shifted - {1'b0, divisor}) : SymW'(shifted);
         // top quotient bit is always zero for q >= 2 and drops out
         quo_in = {quo_ff[RecipW-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         step_ff <= LAST_STEP;
         rem_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         rem_ff  <= rem_in;
      end
      quo_ff <= quo_in;
   end

   assign busy  = busy_ff;
   assign recip = quo_ff;

endmodule

// File: src/qsd_syn.sv
// Stages 1-5: symbol range check and partial syndromes (a(k+1) - g*a1) mod q
// via Barrett reduction. Uses qsd_pkg.
module qsd_syn
   import qsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int EstW  = 2 * ProdW - RecipShift;
   localparam int BackW = EstW + SymW;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   item_type it1_ff, it2_ff, it3_ff, it4_ff, it5_ff;
   item_type it2_in, it5_in;

   logic [2:0][ProdW-1:0]   prod2_in, prod2_ff, prod3_ff;
   logic [2:0][2*ProdW-1:0] wide3;
   logic [2:0][EstW-1:0]    est3_in, est3_ff;
   logic [2:0][BackW-1:0]   back4;
   logic [2:0][RemW-1:0]    rem4_in, rem4_ff;
   logic [2:0][RemW-1:0]    red5;
   logic [2:0][SymW:0]      diff5;

   assign rdy5     = !v5_ff || out_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      it2_in     = it1_ff;
      it2_in.bad = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if ((3'(k) < cfg.len) && (it1_ff.sym[k] >= cfg.q)) begin
            it2_in.bad = 1'b1;
         end
      end
      for (int k = 0; k < 3; k++) begin
         prod2_in[k] = ProdW'(cfg.gen[k]) * ProdW'(it1_ff.sym[0]);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wide3[k]   = (2 * ProdW)'(prod2_ff[k]) * (2 * ProdW)'(cfg.recip);
         est3_in[k] = wide3[k][2*ProdW-1:RecipShift];
      end
   end

   // Barrett estimate is at most one short, so the residue stays below 2q
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         back4[k]   = BackW'(est3_ff[k]) * BackW'(cfg.q);
         rem4_in[k] = RemW'(prod3_ff[k] - back4[k][ProdW-1:0]);
      end
   end

   always_comb begin
      it5_in = it4_ff;
      for (int k = 0; k < 3; k++) begin
         red5[k]  = (rem4_ff[k] >= {1'b0, cfg.q}) ? rem4_ff[k] - {1'b0, cfg.q} : rem4_ff[k];
         diff5[k] = {1'b0, it4_ff.sym[k+1]} - red5[k];
         if (3'(k + 1) >= cfg.len) begin
            it5_in.syn[k] = '0;
         end else if ({1'b0, it4_ff.sym[k+1]} >= red5[k]) begin
            it5_in.syn[k] = diff5[k][SymW-1:0];
         end else begin
            it5_in.syn[k] = SymW'(diff5[k] + {1'b0, cfg.q});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
      if (rdy1) begin
         it1_ff <= in_item;
      end
      if (rdy2) begin
         it2_ff   <= it2_in;
         prod2_ff <= prod2_in;
      end
      if (rdy3) begin
         it3_ff   <= it2_ff;
         prod3_ff <= prod2_ff;
         est3_ff  <= est3_in;
      end
      if (rdy4) begin
         it4_ff  <= it3_ff;
         rem4_ff <= rem4_in;
      end
      if (rdy5) begin
         it5_ff <= it5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_item  = it5_ff;

endmodule

// File: src/qsd_loc.sv
// Stages 6-8: packs the syndromes into a table index, checks it against the
// table depth and writes or reads the error table. Uses qsd_pkg.
module qsd_loc
   import qsd_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int SYMBOL_BITS = SymbolBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  item_type                 in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output item_type                 out_item,
   output logic [4*SYMBOL_BITS-1:0] out_entry
);

   localparam int AddrW  = $clog2(TABLE_DEPTH);
   localparam int EntryW = 4 * SYMBOL_BITS;
   localparam logic [KeyW-1:0] DEPTH_KEY = KeyW'(TABLE_DEPTH);

   logic v6_ff, v7_ff, v8_ff;
   logic rdy6, rdy7, rdy8;
   item_type it6_ff, it7_ff, it8_ff;
   item_type it6_in, it7_in, it8_in;

   logic [ProdW-1:0]  mid6;
   logic              hit7;
   logic              move8;
   logic [AddrW-1:0]  addr7;
   logic [EntryW-1:0] wdata7;
   logic [EntryW-1:0] ent_ff;
   logic [EntryW-1:0] err_mem [TABLE_DEPTH];

   assign rdy8     = !v8_ff || out_ready;
   assign rdy7     = !v7_ff || rdy8;
   assign rdy6     = !v6_ff || rdy7;
   assign in_ready = rdy6;

   // index = s1 + q*(s2 + q*s3), one multiply per stage
   always_comb begin
      mid6       = ProdW'(in_item.syn[2]) * ProdW'(cfg.q) + ProdW'(in_item.syn[1]);
      it6_in     = in_item;
      it6_in.key = KeyW'(mid6);
   end

   always_comb begin
      it7_in = it6_ff;
      if (it6_ff.op == OP_LOAD) begin
         it7_in.key = KeyW'(it6_ff.entry);
      end else begin
         it7_in.key = KeyW'(it6_ff.key[ProdW-1:0]) * KeyW'(cfg.q) + KeyW'(it6_ff.syn[0]);
      end
   end

   always_comb begin
      hit7       = it7_ff.key < DEPTH_KEY;
      addr7      = it7_ff.key[AddrW-1:0];
      move8      = v7_ff && rdy8;
      wdata7     = {SYMBOL_BITS'(it7_ff.err[3]), SYMBOL_BITS'(it7_ff.err[2]),
                    SYMBOL_BITS'(it7_ff.err[1]), SYMBOL_BITS'(it7_ff.err[0])};
      it8_in     = it7_ff;
      it8_in.hit = hit7;
   end

   // loads and decodes pass this stage in order, so a read sees every earlier write
   always_ff @(posedge clock) begin
      if (move8 && hit7 && (it7_ff.op == OP_LOAD)) begin
         err_mem[addr7] <= wdata7;
      end
      if (move8 && hit7 && (it7_ff.op == OP_DECODE)) begin
         ent_ff <= err_mem[addr7];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         if (rdy6) v6_ff <= in_valid;
         if (rdy7) v7_ff <= v6_ff;
         if (rdy8) v8_ff <= v7_ff;
      end
      if (rdy6) it6_ff <= it6_in;
      if (rdy7) it7_ff <= it7_in;
      if (rdy8) it8_ff <= it8_in;
   end

   assign out_valid = v8_ff;
   assign out_item  = it8_ff;
   assign out_entry = ent_ff;

endmodule

// File: src/qsd_fix.sv
// Stages 9-11: reduces the stored error components mod q, subtracts them
// from the received symbols and forms the result beat. Uses qsd_pkg.
module qsd_fix
   import qsd_pkg::*;
#(
   parameter int SYMBOL_BITS = SymbolBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  item_type                 in_item,
   input  logic [4*SYMBOL_BITS-1:0] in_entry,
   output logic                     out_valid,
   input  logic                     out_ready,
   output result_type               out_result
);

   localparam int FixW  = SYMBOL_BITS + RecipW;
   localparam int EstW  = FixW - RecipShift;
   localparam int BackW = EstW + SymW + 2;

   logic v9_ff, v10_ff, v11_ff;
   logic rdy9, rdy10, rdy11;
   item_type it9_ff, it10_ff;
   result_type res_in, res_ff;

   logic [3:0][SYMBOL_BITS-1:0] comp9, ent9_ff;
   logic [3:0][FixW-1:0]        wide9;
   logic [3:0][EstW-1:0]        est9_in, est9_ff;
   logic [3:0][BackW-1:0]       back10;
   logic [3:0][RemW-1:0]        rem10_in, rem10_ff;
   logic [3:0][SymW-1:0]        emod11;
   logic [3:0][SymW:0]          diff11;
   logic [3:0][SymW-1:0]        word11;

   assign rdy11    = !v11_ff || out_ready;
   assign rdy10    = !v10_ff || rdy11;
   assign rdy9     = !v9_ff || rdy10;
   assign in_ready = rdy9;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         comp9[k]   = in_entry[k*SYMBOL_BITS +: SYMBOL_BITS];
         wide9[k]   = FixW'(comp9[k]) * FixW'(cfg.recip);
         est9_in[k] = wide9[k][FixW-1:RecipShift];
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         back10[k]   = BackW'(est9_ff[k]) * BackW'(cfg.q);
         rem10_in[k] = RemW'(ent9_ff[k]) - back10[k][RemW-1:0];
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         emod11[k] = (rem10_ff[k] >= {1'b0, cfg.q}) ? SymW'(rem10_ff[k] - {1'b0, cfg.q})
                                                   : SymW'(rem10_ff[k]);
         diff11[k] = {1'b0, it10_ff.sym[k]} - {1'b0, emod11[k]};
         if (3'(k) >= cfg.len) begin
            word11[k] = '0;
         end else if (it10_ff.sym[k] >= emod11[k]) begin
            word11[k] = diff11[k][SymW-1:0];
         end else begin
            word11[k] = SymW'(diff11[k] + {1'b0, cfg.q});
         end
      end
      res_in = '0;
      if (it10_ff.op == OP_LOAD) begin
         res_in.status = it10_ff.hit ? ST_WRITTEN : ST_RANGE;
      end else if (it10_ff.bad) begin
         res_in.status = ST_SYMBOL;
      end else begin
         res_in.syn      = it10_ff.syn;
         res_in.codeword = (it10_ff.syn == '0);
         if (it10_ff.hit) begin
            res_in.status = ST_DECODED;
            res_in.index  = it10_ff.key[IdxW-1:0];
            res_in.word   = word11;
         end else begin
            res_in.status = ST_RANGE;
            res_in.index  = IDX_SAT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else begin
         if (rdy9)  v9_ff  <= in_valid;
         if (rdy10) v10_ff <= v9_ff;
         if (rdy11) v11_ff <= v10_ff;
      end
      if (rdy9) begin
         it9_ff  <= in_item;
         ent9_ff <= comp9;
         est9_ff <= est9_in;
      end
      if (rdy10) begin
         it10_ff  <= it9_ff;
         rem10_ff <= rem10_in;
      end
      if (rdy11) begin
         res_ff <= res_in;
      end
   end

   assign out_valid  = v11_ff;
   assign out_result = res_ff;

endmodule

// File: src/qary_syndrome_table_decoder.sv
// Channel   Dir   Handshake              Payload
// req_      in    req_tvalid/req_tready  tuser op, tdata entry/errors/symbols
// rsp_      out   rsp_tvalid/rsp_tready  tuser status, tdata words/syndromes/index
// csr_      in    csr_wen                csr_addr register, csr_wdata value
//
// One beat per cycle sustained while rsp_tready stays high and the divider is idle.
// Eleven register stages, each holding its beat under a stall; bubbles close up.
// After reset and after each modulus write the serial reciprocal divider runs,
// and req_tready stays low until it is done.
// Depends on qsd_pkg, qsd_recip, qsd_syn, qsd_loc, qsd_fix.
module qary_syndrome_table_decoder
   import qsd_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int SYMBOL_BITS = SymbolBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // entry_index, err_one..err_four, sym_one..sym_four
   input  logic [ReqDataW-1:0] req_tdata,
   // op
   input  logic                req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // word_one..word_four, part_syn_one..three, syndrome_index, was_codeword, zero pad
   output logic [RspDataW-1:0] rsp_tdata,
   // status
   output logic [1:0]          rsp_tuser,
   input  logic                csr_wen,
   input  logic [2:0]          csr_addr,
   input  logic [SymW-1:0]     csr_wdata
);

   logic [2:0]    len_ff;
   sym_type       mod_ff;
   sym_type [2:0] gen_ff;
   cfg_type       cfg;

   logic              recip_busy;
   logic [RecipW-1:0] recip;
   logic              recip_start;

   item_type   req_item;
   logic       syn_in_ready, syn_valid, syn_ready;
   item_type   syn_item;
   logic       loc_valid, loc_ready;
   item_type   loc_item;
   logic [4*SYMBOL_BITS-1:0] loc_entry;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= LEN_RESET;
         mod_ff    <= MOD_RESET;
         gen_ff[0] <= GEN2_RESET;
         gen_ff[1] <= GEN3_RESET;
         gen_ff[2] <= GEN4_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            REG_LENGTH:     len_ff    <= csr_wdata[2:0];
            REG_MODULUS:    mod_ff    <= csr_wdata;
            REG_GEN_SECOND: gen_ff[0] <= csr_wdata;
            REG_GEN_THIRD:  gen_ff[1] <= csr_wdata;
            REG_GEN_FOURTH: gen_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.len   = (len_ff < LEN_MIN) ? LEN_MIN : ((len_ff > LEN_MAX) ? LEN_MAX : len_ff);
      cfg.q     = (mod_ff < MOD_MIN) ? MOD_MIN : mod_ff;
      cfg.gen   = gen_ff;
      cfg.recip = recip;
   end

   assign recip_start = csr_wen && (csr_addr == REG_MODULUS);

   qsd_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (recip_start),
      .divisor (cfg.q),
      .busy    (recip_busy),
      .recip   (recip)
   );

   always_comb begin
      req_item       = '0;
      req_item.op    = req_tuser;
      req_item.entry = req_tdata[IdxW-1:0];
      for (int k = 0; k < 4; k++) begin
         req_item.err[k] = req_tdata[IdxW + k*SymW +: SymW];
         req_item.sym[k] = req_tdata[IdxW + (4 + k)*SymW +: SymW];
      end
   end

   assign req_tready = syn_in_ready && !recip_busy;

   qsd_syn u_syn (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid && !recip_busy),
      .in_ready  (syn_in_ready),
      .in_item   (req_item),
      .out_valid (syn_valid),
      .out_ready (syn_ready),
      .out_item  (syn_item)
   );

   qsd_loc #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_loc (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (syn_valid),
      .in_ready  (syn_ready),
      .in_item   (syn_item),
      .out_valid (loc_valid),
      .out_ready (loc_ready),
      .out_item  (loc_item),
      .out_entry (loc_entry)
   );

   qsd_fix #(
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_fix (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (loc_valid),
      .in_ready   (loc_ready),
      .in_item    (loc_item),
      .in_entry   (loc_entry),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tuser = result.status;
   assign rsp_tdata = {(RspDataW - 4*SymW - 3*SymW - IdxW - 1)'(0), result.codeword,
                       result.index, result.syn[2], result.syn[1], result.syn[0],
                       result.word[3], result.word[2], result.word[1], result.word[0]};

endmodule

// File: bench/qary_syndrome_table_decoder_tb.sv
// Self-checking bench for qary_syndrome_table_decoder: loads error-table entries,
// decodes vectors under a range of code settings and checks every result beat.
// Depends on qsd_pkg and the decoder RTL only.
module qary_syndrome_table_decoder_tb;
   import qsd_pkg::*;

   localparam int TableEntries = 65536;
   localparam int CycleLimit   = 400000;
   localparam int HoldCycles   = 80;
   localparam int PhaseBeats   = 130;

   typedef struct packed {
      logic          drain;   // wait for every result before offering this beat
      logic          op;
      logic [15:0]   entry;
      sym_type [3:0] err;
      sym_type [3:0] sym;
   } decoder_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic                req_tuser  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                csr_wen    = 1'b0;
   logic [2:0]          csr_addr   = REG_LENGTH;
   sym_type             csr_wdata  = '0;

   // register image as the decoder should hold it
   logic [2:0]    cfg_len = LEN_RESET;
   sym_type       cfg_q   = MOD_RESET;
   sym_type [2:0] cfg_gen = {GEN4_RESET, GEN3_RESET, GEN2_RESET};

   logic [59:0] error_entries [TableEntries];
   bit          entry_loaded  [TableEntries];

   decoder_beat_type  beats_pending [$];
   result_type        outcomes_due  [$];
   longint unsigned   recent_keys   [$];

   int unsigned beats_sent    = 0;
   int unsigned results_seen  = 0;
   int unsigned cycle_count   = 0;
   int          mismatches    = 0;
   int          send_idle_pct = 24;
   int          recv_idle_pct = 60;
   int          holds_wanted  = 0;
   int          holds_served  = 0;
   int          hold_left     = 0;

   qary_syndrome_table_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- arithmetic

   function automatic longint unsigned active_q();
      if (cfg_q < MOD_MIN) begin
         return 2;
      end
      return longint'(cfg_q);
   endfunction

   function automatic int active_len();
      if (cfg_len < LEN_MIN) begin
         return 2;
      end
      if (cfg_len > LEN_MAX) begin
         return 4;
      end
      return int'(cfg_len);
   endfunction

   function automatic bit symbols_in_range(sym_type [3:0] s);
      bit ok;
      ok = 1'b1;
      for (int k = 0; k < active_len(); k++) begin
         if (longint'(s[k]) >= active_q()) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // k-th partial syndrome, zero past the code length
   function automatic longint unsigned partial_syndrome(int k, sym_type [3:0] s);
      longint unsigned q;
      longint unsigned g;
      q = active_q();
      if (k + 1 >= active_len()) begin
         return 0;
      end
      g = longint'(cfg_gen[k]) % q;
      return ((q - g) * longint'(s[0]) + longint'(s[k + 1])) % q;
   endfunction

   function automatic longint unsigned syndrome_key(sym_type [3:0] s);
      longint unsigned q;
      q = active_q();
      return partial_syndrome(0, s) + q * partial_syndrome(1, s)
             + q * q * partial_syndrome(2, s);
   endfunction

   // result of one beat; a load also updates the error table image
   function automatic result_type decode_outcome(logic op, logic [ReqDataW-1:0] d);
      result_type      r;
      sym_type [3:0]   s;
      logic [59:0]     e;
      longint unsigned q;
      longint unsigned key;
      longint unsigned ek;
      r = '0;
      s = d[135:76];
      q = active_q();
      if (op == OP_LOAD) begin
         error_entries[d[15:0]] = d[75:16];
         r.status = ST_WRITTEN;
         return r;
      end
      if (!symbols_in_range(s)) begin
         r.status = ST_SYMBOL;
         return r;
      end
      for (int k = 0; k < 3; k++) begin
         r.syn[k] = sym_type'(partial_syndrome(k, s));
      end
      r.codeword = (r.syn == '0);
      key = syndrome_key(s);
      if (key >= TableEntries) begin
         r.status = ST_RANGE;
         r.index  = IDX_SAT;
         return r;
      end
      r.index = key[15:0];
      e = error_entries[key[15:0]];
      for (int k = 0; k < active_len(); k++) begin
         ek = longint'(e[15 * k +: 15]) % q;
         r.word[k] = sym_type'((longint'(s[k]) + q - ek) % q);
      end
      r.status = ST_DECODED;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic sym_type rand15();
      return sym_type'($urandom_range(32767));
   endfunction

   function automatic sym_type [3:0] random_err();
      return {rand15(), rand15(), rand15(), rand15()};
   endfunction

   function automatic sym_type [3:0] vec(int a1, int a2, int a3, int a4);
      return {sym_type'(a4), sym_type'(a3), sym_type'(a2), sym_type'(a1)};
   endfunction

   task automatic queue_beat(decoder_beat_type b);
      if (b.op == OP_LOAD) begin
         entry_loaded[b.entry] = 1'b1;
      end
      beats_pending.push_back(b);
   endtask

   task automatic queue_load(logic [15:0] idx, sym_type [3:0] err);
      decoder_beat_type b;
      b       = '0;
      b.op    = OP_LOAD;
      b.entry = idx;
      b.err   = err;
      b.sym   = random_err();
      queue_beat(b);
   endtask

   // an entry is never read before it has been loaded
   task automatic queue_decode(sym_type [3:0] s);
      decoder_beat_type b;
      longint unsigned  key;
      key = syndrome_key(s);
      if (symbols_in_range(s) && key < TableEntries && !entry_loaded[key[15:0]]) begin
         queue_load(key[15:0], random_err());
      end
      b       = '0;
      b.op    = OP_DECODE;
      b.entry = 16'($urandom_range(65535));
      b.err   = random_err();
      b.sym   = s;
      queue_beat(b);
   endtask

   task automatic queue_random_decode();
      sym_type [3:0]   s;
      longint unsigned q;
      longint unsigned lim;
      longint unsigned key;
      longint unsigned sk;
      int              n;
      int              pick;
      int              src;
      int              pos;
      q = active_q();
      n = active_len();
      s = random_err();
      for (int k = 0; k < n; k++) begin
         s[k] = sym_type'($urandom_range(32'(q - 1)));
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
         pos    = $urandom_range(n - 1);
         s[pos] = sym_type'($urandom_range(32767, 32'(q)));
      end else if (pick < 75) begin
         // aim at a chosen table entry by solving for the trailing symbols
         lim = q;
         if (n > 2) lim = lim * q;
         if (n > 3) lim = lim * q;
         if (lim > TableEntries) lim = TableEntries;
         src = $urandom_range(99);
         if (src < 15) begin
            key = 0;
         end else if (src < 55 && recent_keys.size() != 0) begin
            key = recent_keys[$urandom_range(recent_keys.size() - 1)] % lim;
         end else begin
            key = longint'($urandom_range(32'(lim - 1)));
         end
         recent_keys.push_back(key);
         if (recent_keys.size() > 8) begin
            recent_keys.delete(0);
         end
         for (int k = 1; k < n; k++) begin
            sk   = key % q;
            key  = key / q;
            s[k] = sym_type'((sk + (longint'(cfg_gen[k - 1]) % q) * longint'(s[0])) % q);
         end
      end
      queue_decode(s);
   endtask

   task automatic queue_phase_traffic(int beats);
      for (int i = 0; i < beats; i++) begin
         if ($urandom_range(99) < 18) begin
            queue_load(16'($urandom_range(65535)), random_err());
         end else begin
            queue_random_decode();
         end
         if (i == beats / 2) begin
            beats_pending[beats_pending.size() - 1].drain = 1'b1;
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (beats_pending.size() != 0 || beats_sent != results_seen);
   endtask

   task automatic write_reg(logic [2:0] addr, sym_type value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      case (addr)
         REG_LENGTH:     cfg_len    = value[2:0];
         REG_MODULUS:    cfg_q      = value;
         REG_GEN_SECOND: cfg_gen[0] = value;
         REG_GEN_THIRD:  cfg_gen[1] = value;
         REG_GEN_FOURTH: cfg_gen[2] = value;
         default: ;
      endcase
   endtask

   task automatic run_phase(int len, int q, int g2, int g3, int g4,
                            int send_pct, int recv_pct, bit long_hold);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      write_reg(REG_LENGTH, sym_type'(len));
      write_reg(REG_MODULUS, sym_type'(q));
      write_reg(REG_GEN_SECOND, sym_type'(g2));
      write_reg(REG_GEN_THIRD, sym_type'(g3));
      write_reg(REG_GEN_FOURTH, sym_type'(g4));
      @(negedge clock);
      queue_phase_traffic(PhaseBeats);
      if (long_hold) begin
         holds_wanted++;
      end
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: n=2, q=631, g2=73
      queue_load(16'd0, vec(0, 0, 0, 0));
      queue_decode(vec(0, 0, 0, 0));
      queue_decode(vec(5, 365, 32767, 32767));          // codeword, unused symbols at max
      queue_load(16'hFFFF, vec(32767, 32767, 32767, 32767));
      queue_load(16'd630, vec(32767, 32767, 32767, 32767)); // components above q
      queue_decode(vec(630, 557, 0, 0));
      queue_decode(vec(631, 0, 0, 0));                  // first symbol equal to q
      queue_decode(vec(0, 32767, 0, 0));
      queue_decode(vec(630, 630, 16'h2AAA, 16'h5555));
      queue_load(16'd1, vec(1, 2, 3, 4));
      queue_decode(vec(0, 1, 0, 0));
      queue_load(16'h5555, vec(16'h2AAA, 16'h5555, 16'h2AAA, 16'h5555));
      queue_load(16'hAAAA, vec(16'h5555, 16'h2AAA, 16'h5555, 16'h2AAA));
      queue_decode(vec(1, 0, 0, 0));
      wait_drained();
      queue_phase_traffic(PhaseBeats);
      wait_drained();

      run_phase(3, 2, 1, 0, 1, 24, 60, 1'b0);
      run_phase(4, 31, 5, 30, 17, 24, 60, 1'b1);
      run_phase(4, 32767, 32766, 1, 12345, 24, 60, 1'b0);
      run_phase(0, 0, 32766, 32766, 32767, 60, 24, 1'b0);  // length and modulus clamp
      run_phase(7, 1, 3, 2, 40, 60, 24, 1'b0);
      run_phase(3, 255, 254, 300, 0, 60, 24, 1'b0);        // generator above q
      run_phase(4, 41, 40, 7, 41, 60, 24, 1'b0);
      run_phase(2, 32767, 0, 9, 11, 0, 0, 1'b1);
      run_phase(1, 126, 332, 5, 126, 0, 0, 1'b0);
      run_phase($urandom_range(7), $urandom_range(32767), $urandom_range(32767),
                $urandom_range(32767), $urandom_range(32767), 0, 0, 1'b0);
      run_phase(4, 3, 2, 1, 0, 0, 0, 1'b0);

      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("qary_syndrome_table_decoder regression: pass");
      end else begin
         $display("qary_syndrome_table_decoder regression: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      logic offer;
      offer = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            beats_pending.delete(0);
            beats_sent++;
         end
         if (req_tvalid && !req_tready) begin
            offer = 1'b1;
         end else if (beats_pending.size() != 0) begin
            if (!(beats_pending[0].drain && beats_sent != results_seen)) begin
               offer = ($urandom_range(99) >= send_idle_pct);
            end
         end
         req_tvalid <= offer;
         if (offer) begin
            req_tdata <= {beats_pending[0].sym, beats_pending[0].err, beats_pending[0].entry};
            req_tuser <= beats_pending[0].op;
         end
      end
   end

   // result side ready, with an occasional long hold-off to back the pipe up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served < holds_wanted) begin
         rsp_tready   <= 1'b0;
         hold_left    <= HoldCycles;
         holds_served <= holds_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic flag_field(string field, longint unsigned want, longint unsigned got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("result %0d: %s expected %0d got %0d", results_seen, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            outcomes_due.push_back(decode_outcome(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            for (int k = 0; k < 4; k++) begin
               got.word[k] = rsp_tdata[15 * k +: 15];
            end
            for (int k = 0; k < 3; k++) begin
               got.syn[k] = rsp_tdata[60 + 15 * k +: 15];
            end
            got.index    = rsp_tdata[105 +: 16];
            got.codeword = rsp_tdata[121];
            if (outcomes_due.size() == 0) begin
               flag_field("unexpected beat, status", 0, got.status);
            end else begin
               want = outcomes_due.pop_front();
               if (got.status !== want.status) flag_field("status", want.status, got.status);
               for (int k = 0; k < 4; k++) begin
                  if (got.word[k] !== want.word[k]) begin
                     flag_field($sformatf("word %0d", k + 1), want.word[k], got.word[k]);
                  end
               end
               for (int k = 0; k < 3; k++) begin
                  if (got.syn[k] !== want.syn[k]) begin
                     flag_field($sformatf("partial syndrome %0d", k + 1),
                                want.syn[k], got.syn[k]);
                  end
               end
               if (got.index !== want.index) flag_field("index", want.index, got.index);
               if (got.codeword !== want.codeword) begin
                  flag_field("was_codeword", want.codeword, got.codeword);
               end
            end
            results_seen <= results_seen + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("qary_syndrome_table_decoder regression: fail");
         $finish;
      end
   end

endmodule

// File: sim.f
src/qsd_pkg.sv
src/qsd_recip.sv
src/qsd_syn.sv
src/qsd_loc.sv
src/qsd_fix.sv
src/qary_syndrome_table_decoder.sv
bench/qary_syndrome_table_decoder_tb.sv
